// ===== sv/lpcb_pkg.sv =====
// Package: shared types, codes and channel arithmetic of the layer priority color blender
`timescale 1ns / 1ps

package lpcb_pkg;

    localparam int COLOR_W = 15;
    localparam int CHAN_W  = 5;
    localparam int LAYER_W = 3;
    localparam int PRIO_W  = 3;
    localparam int WGT_W   = 5;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [LAYER_W-1:0] LAYER_OBJ      = 3'd0;
    localparam logic [LAYER_W-1:0] LAYER_BACKDROP = 3'd5;
    localparam logic [PRIO_W-1:0]  PRIO_BEST      = 3'd0;
    localparam logic [PRIO_W-1:0]  PRIO_LAST      = 3'd3;
    localparam logic [PRIO_W-1:0]  PRIO_TRANSP    = 3'd4;
    localparam logic [WGT_W-1:0]   WGT_FULL       = 5'd16;
    localparam logic [CHAN_W-1:0]  CHAN_MAX       = 5'd31;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_ALPHA    = 2'd1,
        MODE_BRIGHTEN = 2'd2,
        MODE_DARKEN   = 2'd3
    } t_effect_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EFFECT_MODE   = 2'd0,
        CFG_WEIGHT_TOP    = 2'd1,
        CFG_WEIGHT_BOTTOM = 2'd2,
        CFG_FADE_AMOUNT   = 2'd3
    } t_cfg_index;

    // Tracking slots; each slot carries the current color of its layer
    typedef struct packed {
        logic [PRIO_W-1:0]  top_prio;
        logic [LAYER_W-1:0] top_sel;
        logic [COLOR_W-1:0] top_color;
        logic [PRIO_W-1:0]  bot0_prio;
        logic [LAYER_W-1:0] bot0_sel;
        logic [COLOR_W-1:0] bot0_color;
        logic [PRIO_W-1:0]  bot1_prio;
        logic [LAYER_W-1:0] bot1_sel;
        logic [COLOR_W-1:0] bot1_color;
        logic [PRIO_W-1:0]  front_prio;
        logic [LAYER_W-1:0] front_sel;
        logic [COLOR_W-1:0] front_color;
        logic               semi_seen;
    } t_track;

    // Limit a weight to sixteen sixteenths
    function automatic logic [WGT_W-1:0] clip16(input logic [WGT_W-1:0] w);
        return (w > WGT_FULL) ? WGT_FULL : w;
    endfunction

    // Weighted sum of two channels, saturated to the channel maximum
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [WGT_W-1:0]  ea,
        input logic [WGT_W-1:0]  eb
    );
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] sum;
        pa  = {5'd0, a} * {5'd0, ea};
        pb  = {5'd0, b} * {5'd0, eb};
        sum = pa + pb;
        return sum[9] ? CHAN_MAX : sum[8:4];
    endfunction

    // Move a channel toward white or black, keeping weight w of sixteen of the channel
    function automatic logic [CHAN_W-1:0] fade_chan(
        input logic [CHAN_W-1:0] c,
        input logic [WGT_W-1:0]  w,
        input logic              brighten
    );
        logic [WGT_W-1:0] inv;
        logic [9:0]       pa;
        logic [9:0]       pb;
        logic [9:0]       sum;
        inv = WGT_FULL - w;
        pa  = {5'd0, c} * {5'd0, w};
        pb  = {5'd0, CHAN_MAX} * {5'd0, inv};
        sum = brighten ? (pa + pb) : pa;
        return sum[8:4];
    endfunction

endpackage

// ===== sv/lpcb_if.sv =====
// Interfaces: layer contribution, resolved pixel and register write channels
`timescale 1ns / 1ps

interface lpcb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          first_of_pixel;
    logic                          last_of_pixel;
    logic [lpcb_pkg::LAYER_W-1:0]  layer_id;
    logic [lpcb_pkg::PRIO_W-1:0]   prio_level;
    logic                          is_top_target;
    logic                          is_bottom_target;
    logic [lpcb_pkg::COLOR_W-1:0]  pixel_in;
    logic                          obj_semi_trans;

    modport source (
        output valid, first_of_pixel, last_of_pixel, layer_id, prio_level,
               is_top_target, is_bottom_target, pixel_in, obj_semi_trans,
        input  ready
    );
    modport sink (
        input  valid, first_of_pixel, last_of_pixel, layer_id, prio_level,
               is_top_target, is_bottom_target, pixel_in, obj_semi_trans,
        output ready
    );
endinterface

interface lpcb_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpcb_pkg::COLOR_W-1:0]  pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink (input valid, pixel_out, output ready);
endinterface

interface lpcb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpcb_pkg::CFG_IDX_W-1:0]  index;
    logic [lpcb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/layer_priority_color_blender.sv =====
// Top level: layer priority tracking and color effect resolve for one pixel at a time
//
//  channel  | dir | word                                         | accepted when
//  ---------+-----+----------------------------------------------+--------------------
//  i_pix    | in  | one layer contribution of a pixel            | valid && ready
//  o_pix    | out | resolved 15-bit pixel color                  | valid && ready
//  i_cfg    | in  | register index and write data                | valid && ready
//
//  One contribution is taken per cycle while i_pix.ready is high; tracking slots
//  update at acceptance. A pixel's last word lands in a snapshot register, is
//  resolved from it and passes through the output register to o_pix.
//  Reset clears slot priorities, selects, config registers and valid flags.
//  A stalled o_pix holds the snapshot; i_pix.ready drops only when both hold.
`timescale 1ns / 1ps

module layer_priority_color_blender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpcb_in_if.sink     i_pix,
    lpcb_out_if.source  o_pix,
    lpcb_cfg_if.sink    i_cfg
);

    // Configuration registers
    lpcb_pkg::t_effect_mode          r_mode;
    logic [lpcb_pkg::WGT_W-1:0]      r_wgt_top;
    logic [lpcb_pkg::WGT_W-1:0]      r_wgt_bot;
    logic [lpcb_pkg::WGT_W-1:0]      r_fade;

    // Tracking state
    lpcb_pkg::t_track                r_trk;
    lpcb_pkg::t_track                n_trk;
    logic [lpcb_pkg::COLOR_W-1:0]    r_backdrop;
    logic [lpcb_pkg::COLOR_W-1:0]    n_backdrop;

    // Snapshot and output stages
    lpcb_pkg::t_track                r_snap;
    logic                            r_snap_vld;
    logic                            r_out_vld;
    logic [lpcb_pkg::COLOR_W-1:0]    r_out_pixel;
    logic [lpcb_pkg::COLOR_W-1:0]    n_out_pixel;

    logic                            w_in_acc;
    logic                            w_snap_adv;
    logic [lpcb_pkg::PRIO_W-1:0]     w_prio;

    // Resolve signals
    logic                            w_bi;
    logic [lpcb_pkg::PRIO_W-1:0]     w_bprio;
    logic [lpcb_pkg::COLOR_W-1:0]    w_bcolor;
    logic                            w_blend_ok;
    logic                            w_semi_force;
    logic                            w_fade_plain;
    logic [lpcb_pkg::WGT_W-1:0]      w_ea;
    logic [lpcb_pkg::WGT_W-1:0]      w_eb;
    logic [lpcb_pkg::WGT_W-1:0]      w_fw;
    logic [lpcb_pkg::COLOR_W-1:0]    w_mix;
    logic [lpcb_pkg::COLOR_W-1:0]    w_alpha;
    logic [lpcb_pkg::COLOR_W-1:0]    w_faded;

    // Handshakes
    assign w_snap_adv  = !r_out_vld || o_pix.ready;
    assign i_pix.ready = !r_snap_vld || w_snap_adv;
    assign w_in_acc    = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;
    assign o_pix.valid     = r_out_vld;
    assign o_pix.pixel_out = r_out_pixel;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lpcb_pkg::MODE_NONE;
            r_wgt_top <= '0;
            r_wgt_bot <= '0;
            r_fade    <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (lpcb_pkg::t_cfg_index'(i_cfg.index))
                lpcb_pkg::CFG_EFFECT_MODE:
                    r_mode <= lpcb_pkg::t_effect_mode'(i_cfg.data[lpcb_pkg::MODE_W-1:0]);
                lpcb_pkg::CFG_WEIGHT_TOP:    r_wgt_top <= i_cfg.data;
                lpcb_pkg::CFG_WEIGHT_BOTTOM: r_wgt_bot <= i_cfg.data;
                lpcb_pkg::CFG_FADE_AMOUNT:   r_fade    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Apply one contribution to the tracking slots
    assign w_prio = (i_pix.prio_level > lpcb_pkg::PRIO_TRANSP) ?
                    lpcb_pkg::PRIO_TRANSP : i_pix.prio_level;

    always_comb begin
        n_trk      = r_trk;
        n_backdrop = r_backdrop;
        // Clear the slots; they point at the backdrop again
        if (i_pix.first_of_pixel) begin
            n_trk.top_prio    = lpcb_pkg::PRIO_TRANSP;
            n_trk.top_sel     = lpcb_pkg::LAYER_BACKDROP;
            n_trk.top_color   = r_backdrop;
            n_trk.bot0_prio   = lpcb_pkg::PRIO_TRANSP;
            n_trk.bot0_sel    = lpcb_pkg::LAYER_BACKDROP;
            n_trk.bot0_color  = r_backdrop;
            n_trk.bot1_prio   = lpcb_pkg::PRIO_TRANSP;
            n_trk.bot1_sel    = lpcb_pkg::LAYER_BACKDROP;
            n_trk.bot1_color  = r_backdrop;
            n_trk.front_prio  = lpcb_pkg::PRIO_TRANSP;
            n_trk.front_sel   = lpcb_pkg::LAYER_BACKDROP;
            n_trk.front_color = r_backdrop;
            n_trk.semi_seen   = 1'b0;
        end
        if (i_pix.layer_id <= lpcb_pkg::LAYER_BACKDROP) begin
            if (i_pix.layer_id == lpcb_pkg::LAYER_BACKDROP) begin
                n_backdrop = i_pix.pixel_in;
            end
            // Refresh the color of every slot that holds this layer
            if (n_trk.top_sel == i_pix.layer_id) begin
                n_trk.top_color = i_pix.pixel_in;
            end
            if (n_trk.bot0_sel == i_pix.layer_id) begin
                n_trk.bot0_color = i_pix.pixel_in;
            end
            if (n_trk.bot1_sel == i_pix.layer_id) begin
                n_trk.bot1_color = i_pix.pixel_in;
            end
            if (n_trk.front_sel == i_pix.layer_id) begin
                n_trk.front_color = i_pix.pixel_in;
            end
            if (i_pix.layer_id == lpcb_pkg::LAYER_OBJ && i_pix.obj_semi_trans) begin
                // Semi-transparent object takes the top slot only
                n_trk.top_prio  = lpcb_pkg::PRIO_BEST;
                n_trk.top_sel   = lpcb_pkg::LAYER_OBJ;
                n_trk.top_color = i_pix.pixel_in;
                n_trk.semi_seen = 1'b1;
            end else begin
                if (i_pix.is_top_target && w_prio < n_trk.top_prio) begin
                    n_trk.top_prio  = w_prio;
                    n_trk.top_sel   = i_pix.layer_id;
                    n_trk.top_color = i_pix.pixel_in;
                end
                if (i_pix.is_bottom_target) begin
                    if (w_prio < n_trk.bot0_prio) begin
                        n_trk.bot1_prio  = n_trk.bot0_prio;
                        n_trk.bot1_sel   = n_trk.bot0_sel;
                        n_trk.bot1_color = n_trk.bot0_color;
                        n_trk.bot0_prio  = w_prio;
                        n_trk.bot0_sel   = i_pix.layer_id;
                        n_trk.bot0_color = i_pix.pixel_in;
                    end else if (w_prio < n_trk.bot1_prio) begin
                        n_trk.bot1_prio  = w_prio;
                        n_trk.bot1_sel   = i_pix.layer_id;
                        n_trk.bot1_color = i_pix.pixel_in;
                    end
                end
                if (w_prio < n_trk.front_prio) begin
                    n_trk.front_prio  = w_prio;
                    n_trk.front_sel   = i_pix.layer_id;
                    n_trk.front_color = i_pix.pixel_in;
                end
            end
        end
    end

    // Hold the tracking slots between words; colors are payload and skip reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk.top_prio   <= lpcb_pkg::PRIO_TRANSP;
            r_trk.top_sel    <= lpcb_pkg::LAYER_BACKDROP;
            r_trk.bot0_prio  <= lpcb_pkg::PRIO_TRANSP;
            r_trk.bot0_sel   <= lpcb_pkg::LAYER_BACKDROP;
            r_trk.bot1_prio  <= lpcb_pkg::PRIO_TRANSP;
            r_trk.bot1_sel   <= lpcb_pkg::LAYER_BACKDROP;
            r_trk.front_prio <= lpcb_pkg::PRIO_TRANSP;
            r_trk.front_sel  <= lpcb_pkg::LAYER_BACKDROP;
            r_trk.semi_seen  <= 1'b0;
        end else if (w_in_acc) begin
            r_trk <= n_trk;
        end
    end

    // Backdrop color is payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_backdrop <= n_backdrop;
        end
    end

    // Capture the finished slots on the last word of a pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (w_in_acc && i_pix.last_of_pixel) begin
            r_snap_vld <= 1'b1;
        end else if (w_snap_adv) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_pix.last_of_pixel) begin
            r_snap <= n_trk;
        end
    end

    // Pick the bottom slot that is not the top layer itself
    assign w_bi     = (r_snap.top_sel == r_snap.bot0_sel);
    assign w_bprio  = w_bi ? r_snap.bot1_prio  : r_snap.bot0_prio;
    assign w_bcolor = w_bi ? r_snap.bot1_color : r_snap.bot0_color;

    assign w_blend_ok = !(r_snap.top_prio > r_snap.front_prio ||
                          r_snap.top_prio > w_bprio ||
                          r_snap.top_prio > lpcb_pkg::PRIO_LAST ||
                          w_bprio > lpcb_pkg::PRIO_LAST);
    assign w_semi_force = r_snap.semi_seen && r_snap.top_sel == lpcb_pkg::LAYER_OBJ &&
                          r_snap.bot0_sel != lpcb_pkg::LAYER_BACKDROP;
    assign w_fade_plain = r_snap.top_prio > r_snap.front_prio ||
                          r_snap.top_sel == lpcb_pkg::LAYER_BACKDROP;

    assign w_ea = lpcb_pkg::clip16(r_wgt_top);
    assign w_eb = lpcb_pkg::clip16(r_wgt_bot);
    assign w_fw = lpcb_pkg::WGT_FULL - lpcb_pkg::clip16(r_fade);

    // Per-channel blend and fade
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_mix[ch*5 +: 5]   = lpcb_pkg::blend_chan(r_snap.top_color[ch*5 +: 5],
                                                      w_bcolor[ch*5 +: 5], w_ea, w_eb);
            w_faded[ch*5 +: 5] = lpcb_pkg::fade_chan(r_snap.top_color[ch*5 +: 5], w_fw,
                                                     r_mode == lpcb_pkg::MODE_BRIGHTEN);
        end
    end

    assign w_alpha = w_blend_ok ? w_mix : r_snap.front_color;

    // Select the effect
    always_comb begin
        case (r_mode)
            lpcb_pkg::MODE_ALPHA: n_out_pixel = w_alpha;
            lpcb_pkg::MODE_BRIGHTEN,
            lpcb_pkg::MODE_DARKEN: begin
                if (w_fade_plain) begin
                    n_out_pixel = r_snap.front_color;
                end else if (w_semi_force) begin
                    n_out_pixel = w_alpha;
                end else begin
                    n_out_pixel = w_faded;
                end
            end
            default: n_out_pixel = w_semi_force ? w_alpha : r_snap.front_color;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_snap_adv) begin
            r_out_vld <= r_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_adv && r_snap_vld) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    // Checks
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_vld && !w_snap_adv |=> r_snap_vld)
        else $error("pending snapshot dropped while output stalled");

    a_out_from_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_snap_vld))
        else $error("output word without a snapshot");

    a_front_le_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trk.front_prio <= r_trk.bot0_prio && r_trk.bot0_prio <= r_trk.bot1_prio)
        else $error("priority ordering of tracking slots broken");

    a_clear_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_pix.first_of_pixel &&
        i_pix.layer_id > lpcb_pkg::LAYER_BACKDROP
        |=> r_trk.front_prio == lpcb_pkg::PRIO_TRANSP && !r_trk.semi_seen)
        else $error("first word did not clear tracking");

endmodule
